// ----- design/mjt_pkg.sv -----
// Package for the minimum-jerk waypoint tracker: shared types and constants.
// Used by the axis lane, the sequencer and the top level. No dependencies.
`default_nettype none
package mjt_pkg;
    localparam int POS_W = 32;
    localparam int DUR_W = 26;
    localparam int PROG_W = 17;
    localparam int GAIN_W = 16;
    localparam int CNT_W = 4;
    localparam int TICK_W = 16;
    localparam int S_W = 40;
    localparam int MAX_WAYPOINTS = 8;
    localparam logic [PROG_W-1:0] PROG_ONE = 17'h10000;
    localparam logic [19:0] US_PER_S = 20'd1000000;

    localparam logic CFG_WAYPOINT_COUNT = 1'b0;
    localparam logic CFG_POSITION_GAIN = 1'b1;

    // operands handed from the sequencer to both lanes
    typedef struct packed {
        logic signed [S_W-1:0] s;
        logic signed [S_W-1:0] ds;
        logic [DUR_W-1:0]      dur;
        logic                  dur_zero;
        logic [GAIN_W-1:0]     gain;
    } lane_cmd_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            return 32'sh80000000;
        else
            return v[POS_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/min_jerk_waypoint_tracker.sv -----
// Top level of the two-axis minimum-jerk waypoint tracker.
// Depends on mjt_pkg, mjt_timebase and two mjt_lane instances.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item.
//   mode 1 writes a waypoint table entry and gives no result; mode 0 is a
//   control tick that gives one result on the output channel
//   (out_valid/out_ready). Configuration is a plain write port (cfg_we,
//   cfg_index, cfg_data) that the user writes only while the block is idle;
//   the block itself does not enforce this.
// Sequencing:
//   a tick raises out_valid after the 42-step progress division and five
//   polynomial steps in the timebase, then the 73-step feedforward
//   division by T in each axis lane, which run side by side. A zero
//   duration skips both divisions. One tick is in flight at a time; the
//   next input is taken the cycle after the result is loaded.
// Reset: start point, segment time, slot and the started flag clear; the
//   table is undefined until written; waypoint_count resets to 1 and
//   position_gain to 1.0.
// Stall: a result held in the output register waits for out_ready; the
//   next input is taken meanwhile, and its result waits at the merge stage
//   (input held off) until the output register frees up.
`default_nettype none
module min_jerk_waypoint_tracker
    import mjt_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [GAIN_W-1:0]        cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     mode,
    input  wire logic [2:0]               entry_index,
    input  wire logic signed [POS_W-1:0]  entry_x,
    input  wire logic signed [POS_W-1:0]  entry_y,
    input  wire logic [DUR_W-1:0]         entry_duration,
    input  wire logic signed [POS_W-1:0]  measured_x,
    input  wire logic signed [POS_W-1:0]  measured_y,
    input  wire logic [TICK_W-1:0]        tick_us,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [POS_W-1:0]       velocity_x,
    output logic signed [POS_W-1:0]       velocity_y,
    output logic signed [POS_W-1:0]       desired_x,
    output logic signed [POS_W-1:0]       desired_y,
    output logic [PROG_W-1:0]             progress,
    output logic [2:0]                    target_slot,
    output logic                          segment_done
);
    localparam int SW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_TIME, S_LANE, S_HOLD} state_t;

    logic signed [POS_W-1:0] tab_x [MAX_WAYPOINTS];
    logic signed [POS_W-1:0] tab_y [MAX_WAYPOINTS];
    logic [DUR_W-1:0]        tab_d [MAX_WAYPOINTS];

    state_t                  state_reg;
    logic [CNT_W-1:0]        wcount_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic signed [POS_W-1:0] sx_reg, sy_reg, mx_reg, my_reg, tx_reg, ty_reg;
    logic [DUR_W-1:0]        segt_reg, dur_reg;
    logic [SW-1:0]           slot_reg;
    logic                    started_reg;
    logic                    tb_start_reg, ln_start_reg;
    logic                    ldx_reg, ldy_reg;

    logic                    tb_done, lx_done, ly_done;
    logic [PROG_W-1:0]       tb_prog;
    logic signed [S_W-1:0]   tb_s, tb_ds;
    logic signed [POS_W-1:0] lx_des, ly_des, lx_vel, ly_vel;
    lane_cmd_t               cmd;

    logic [DUR_W:0]          segt_sum;
    logic [DUR_W-1:0]        segt_next;
    logic [CNT_W-1:0]        cnt_eff;
    logic [SW:0]             slot_inc;
    logic                    done_now;

    assign in_ready = (state_reg == S_IDLE);
    assign segt_sum = started_reg ? ({1'b0, segt_reg} + (DUR_W+1)'(tick_us)) : '0;
    assign segt_next = (segt_sum > {1'b0, tab_d[slot_reg]}) ? tab_d[slot_reg]
                                                            : segt_sum[DUR_W-1:0];
    assign done_now = (tb_prog >= PROG_ONE);
    assign slot_inc = {1'b0, slot_reg} + 1'b1;

    always_comb
    begin
        cnt_eff = wcount_reg;
        if (cnt_eff == '0)
            cnt_eff = CNT_W'(1);
        if (32'(cnt_eff) > MAX_WAYPOINTS)
            cnt_eff = CNT_W'(MAX_WAYPOINTS);
    end

    assign cmd.s        = tb_s;
    assign cmd.ds       = tb_ds;
    assign cmd.dur      = dur_reg;
    assign cmd.dur_zero = (dur_reg == '0);
    assign cmd.gain     = gain_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && mode && (32'(entry_index) < MAX_WAYPOINTS))
        begin
            tab_x[entry_index[SW-1:0]] <= entry_x;
            tab_y[entry_index[SW-1:0]] <= entry_y;
            tab_d[entry_index[SW-1:0]] <= entry_duration;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wcount_reg   <= CNT_W'(1);
            gain_reg     <= 16'd256;
            sx_reg       <= '0;
            sy_reg       <= '0;
            segt_reg     <= '0;
            slot_reg     <= '0;
            started_reg  <= 1'b0;
            tb_start_reg <= 1'b0;
            ln_start_reg <= 1'b0;
            ldx_reg      <= 1'b0;
            ldy_reg      <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            tb_start_reg <= 1'b0;
            ln_start_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WAYPOINT_COUNT)
                    wcount_reg <= cfg_data[CNT_W-1:0];
                else
                    gain_reg <= cfg_data;
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !mode)
                    begin
                        mx_reg   <= measured_x;
                        my_reg   <= measured_y;
                        tx_reg   <= tab_x[slot_reg];
                        ty_reg   <= tab_y[slot_reg];
                        dur_reg  <= tab_d[slot_reg];
                        segt_reg <= segt_next;
                        if (!started_reg)
                        begin
                            sx_reg      <= measured_x;
                            sy_reg      <= measured_y;
                            started_reg <= 1'b1;
                        end
                        tb_start_reg <= 1'b1;
                        state_reg    <= S_TIME;
                    end
                end
                S_TIME:
                begin
                    if (tb_done)
                    begin
                        ln_start_reg <= 1'b1;
                        ldx_reg      <= 1'b0;
                        ldy_reg      <= 1'b0;
                        state_reg    <= S_LANE;
                    end
                end
                S_LANE:
                begin
                    if (lx_done)
                        ldx_reg <= 1'b1;
                    if (ly_done)
                        ldy_reg <= 1'b1;
                    if ((ldx_reg || lx_done) && (ldy_reg || ly_done))
                        state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    // merge: wait for the output register to free up
                    if (!out_valid || out_ready)
                    begin
                        out_valid    <= 1'b1;
                        velocity_x   <= lx_vel;
                        velocity_y   <= ly_vel;
                        desired_x    <= lx_des;
                        desired_y    <= ly_des;
                        progress     <= tb_prog;
                        target_slot  <= 3'(slot_reg);
                        segment_done <= done_now;
                        if (done_now)
                        begin
                            slot_reg <= (slot_inc >= (SW+1)'(cnt_eff)) ? '0
                                                                       : slot_inc[SW-1:0];
                            sx_reg   <= mx_reg;
                            sy_reg   <= my_reg;
                            segt_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    mjt_timebase u_time (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tb_start_reg),
        .seg_time (segt_reg),
        .dur      (dur_reg),
        .done     (tb_done),
        .prog     (tb_prog),
        .s        (tb_s),
        .ds       (tb_ds)
    );

    mjt_lane u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ln_start_reg),
        .cmd      (cmd),
        .x0       (sx_reg),
        .xf       (tx_reg),
        .meas     (mx_reg),
        .done     (lx_done),
        .desired  (lx_des),
        .velocity (lx_vel)
    );

    mjt_lane u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ln_start_reg),
        .cmd      (cmd),
        .x0       (sy_reg),
        .xf       (ty_reg),
        .meas     (my_reg),
        .done     (ly_done),
        .desired  (ly_des),
        .velocity (ly_vel)
    );
endmodule
`default_nettype wire

// ----- design/mjt_lane.sv -----
// One axis lane: desired position, feedforward and feedback velocity.
// Depends on mjt_pkg. A multi-cycle sequence; the divide by T is restoring.
`default_nettype none
module mjt_lane
    import mjt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire lane_cmd_t               cmd,
    input  wire logic signed [POS_W-1:0] x0,
    input  wire logic signed [POS_W-1:0] xf,
    input  wire logic signed [POS_W-1:0] meas,
    output logic                         done,
    output logic signed [POS_W-1:0]      desired,
    output logic signed [POS_W-1:0]      velocity
);
    typedef enum logic [2:0] {L_IDLE, L_MUL, L_DES, L_FB, L_DIV, L_OUT} lstate_t;

    lstate_t                 state_reg;
    logic signed [32:0]      d_reg;
    logic signed [72:0]      ps_reg, pd_reg;
    logic signed [POS_W-1:0] des_reg;
    logic signed [55:0]      fb_reg;
    logic signed [72:0]      p_reg;
    logic [72:0]             num_reg, quo_reg;
    logic [DUR_W:0]          rem_reg;
    logic [6:0]              bit_reg;
    logic                    neg_reg;

    logic signed [72:0] des_full, pfull;
    logic [DUR_W:0]     rem_try;
    logic signed [72:0] ff;

    // 33x38 products are registered in their own state, L_MUL
    assign des_full = $signed({{40{x0[31]}}, x0}) + (ps_reg >>> 30);
    assign pfull    = pd_reg >>> 28;
    assign rem_try  = {rem_reg[DUR_W-1:0], num_reg[72]};
    assign ff       = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        d_reg     <= 33'(xf) - 33'(x0);
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    ps_reg    <= 73'(d_reg) * 73'(cmd.s >>> 2);
                    pd_reg    <= 73'(d_reg) * 73'(cmd.ds >>> 4);
                    state_reg <= L_DES;
                end
                L_DES:
                begin
                    des_reg <= cmd.dur_zero ? xf : sat32(des_full[71:0]);
                    p_reg   <= pfull * $signed({53'd0, US_PER_S});
                    state_reg <= L_FB;
                end
                L_FB:
                begin
                    fb_reg  <= $signed({1'b0, cmd.gain}) *
                               (56'(des_reg) - 56'(meas));
                    neg_reg <= p_reg[72];
                    num_reg <= p_reg[72] ? 73'(-p_reg) : 73'(p_reg);
                    quo_reg <= '0;
                    rem_reg <= '0;
                    bit_reg <= 7'd73;
                    state_reg <= cmd.dur_zero ? L_OUT : L_DIV;
                end
                L_DIV:
                begin
                    if (rem_try >= {1'b0, cmd.dur})
                    begin
                        rem_reg <= rem_try - {1'b0, cmd.dur};
                        quo_reg <= {quo_reg[71:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_try;
                        quo_reg <= {quo_reg[71:0], 1'b0};
                    end
                    num_reg <= {num_reg[71:0], 1'b0};
                    bit_reg <= bit_reg - 7'd1;
                    if (bit_reg == 7'd1)
                        state_reg <= L_OUT;
                end
                L_OUT:
                begin
                    desired   <= des_reg;
                    velocity  <= sat32((cmd.dur_zero ? 72'sd0 : ff[71:0]) +
                                       72'(fb_reg >>> 8));
                    done      <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/mjt_timebase.sv -----
// Segment time sequencer: progress division and quintic polynomial terms.
// Depends on mjt_pkg. Produces the shared lane operands.
`default_nettype none
module mjt_timebase
    import mjt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DUR_W-1:0]  seg_time,
    input  wire logic [DUR_W-1:0]  dur,
    output logic                   done,
    output logic [PROG_W-1:0]      prog,
    output logic signed [S_W-1:0]  s,
    output logic signed [S_W-1:0]  ds
);
    typedef enum logic [2:0] {T_IDLE, T_DIV, T_P2, T_P3, T_P4, T_P5, T_SUM} tstate_t;

    tstate_t        state_reg;
    logic [41:0]    num_reg;
    logic [DUR_W:0] rem_reg;
    logic [16:0]    q_reg;
    logic [5:0]     bit_reg;
    logic [33:0]    u2_reg, u3_reg, u4_reg, u5_reg;
    logic [50:0]    prod;
    logic [DUR_W:0] rem_try;

    assign rem_try = {rem_reg[DUR_W-1:0], num_reg[41]};

    always_comb
    begin
        unique case (state_reg)
            T_P3:    prod = 51'(u2_reg) * 51'(prog);
            T_P4:    prod = 51'(u3_reg) * 51'(prog);
            default: prod = 51'(u4_reg) * 51'(prog);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        num_reg <= {seg_time, 16'd0};
                        rem_reg <= '0;
                        q_reg   <= '0;
                        bit_reg <= 6'd42;
                        if (dur == '0)
                        begin
                            prog      <= PROG_ONE;
                            state_reg <= T_P2;
                        end
                        else
                            state_reg <= T_DIV;
                    end
                end
                T_DIV:
                begin
                    // quotient never exceeds 2^16 since seg_time <= dur
                    if (rem_try >= {1'b0, dur})
                    begin
                        rem_reg <= rem_try - {1'b0, dur};
                        q_reg   <= {q_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_try;
                        q_reg   <= {q_reg[15:0], 1'b0};
                    end
                    num_reg <= {num_reg[40:0], 1'b0};
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd1)
                    begin
                        prog      <= (rem_try >= {1'b0, dur}) ?
                                     {q_reg[15:0], 1'b1} : {q_reg[15:0], 1'b0};
                        state_reg <= T_P2;
                    end
                end
                T_P2:
                begin
                    u2_reg    <= 34'(prog) * 34'(prog);
                    state_reg <= T_P3;
                end
                T_P3:
                begin
                    u3_reg    <= prod[49:16];
                    state_reg <= T_P4;
                end
                T_P4:
                begin
                    u4_reg    <= prod[49:16];
                    state_reg <= T_P5;
                end
                T_P5:
                begin
                    u5_reg    <= prod[49:16];
                    state_reg <= T_SUM;
                end
                T_SUM:
                begin
                    s  <= 40'sd10 * $signed({6'd0, u3_reg}) - 40'sd15 * $signed({6'd0, u4_reg})
                          + 40'sd6 * $signed({6'd0, u5_reg});
                    ds <= 40'sd30 * $signed({6'd0, u2_reg}) - 40'sd60 * $signed({6'd0, u3_reg})
                          + 40'sd30 * $signed({6'd0, u4_reg});
                    done      <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
